// File: rtl/qrm_pkg.sv
`timescale 1ns / 1ps

package qrm_pkg;

   localparam int IN_WIDTH      = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
   localparam int PROD_WIDTH    = 2 * IN_WIDTH;
   localparam int SUM_WIDTH     = 2 * IN_WIDTH + 2;
   localparam int DEN_WIDTH     = 2 * IN_WIDTH + 1;
   localparam int QUO_WIDTH     = OUT_FRAC_BITS + 1;
   localparam int NUM_ENTRIES   = 9;
   localparam int DIV_STAGES    = OUT_FRAC_BITS;

   localparam logic [OUT_WIDTH-1:0] FIX_ONE = OUT_WIDTH'(1) << OUT_FRAC_BITS;

   // matrix entry order, row major
   localparam int E_R0C0 = 0;
   localparam int E_R0C1 = 1;
   localparam int E_R0C2 = 2;
   localparam int E_R1C0 = 3;
   localparam int E_R1C1 = 4;
   localparam int E_R1C2 = 5;
   localparam int E_R2C0 = 6;
   localparam int E_R2C1 = 7;
   localparam int E_R2C2 = 8;

   typedef struct packed {
      logic                                     vld;
      logic                                     zero;
      logic [DEN_WIDTH-1:0]                     den;
      logic [NUM_ENTRIES-1:0]                   neg;
      logic [NUM_ENTRIES-1:0][DEN_WIDTH-1:0]    rem;
      logic [NUM_ENTRIES-1:0][QUO_WIDTH-1:0]    quo;
   } div_word_type;

   typedef struct packed {
      logic                                     vld;
      logic                                     zero;
      logic [NUM_ENTRIES-1:0][OUT_WIDTH-1:0]    ent;
   } result_type;

endpackage

// File: rtl/qrm_if.sv
`timescale 1ns / 1ps

interface qrm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [qrm_pkg::IN_WIDTH-1:0]   quat_x;
   logic signed [qrm_pkg::IN_WIDTH-1:0]   quat_y;
   logic signed [qrm_pkg::IN_WIDTH-1:0]   quat_z;
   logic signed [qrm_pkg::IN_WIDTH-1:0]   quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r0c0;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r0c1;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r0c2;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r1c0;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r1c1;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r1c2;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r2c0;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r2c1;
   logic signed [qrm_pkg::OUT_WIDTH-1:0]  r2c2;
   logic                                  zero_length;

   modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                   zero_length, input ready);
   modport sink (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                 zero_length, output ready);
endinterface

// File: rtl/qrm_front.sv
`timescale 1ns / 1ps

module qrm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_vld,
   input  logic signed [qrm_pkg::IN_WIDTH-1:0] in_x,
   input  logic signed [qrm_pkg::IN_WIDTH-1:0] in_y,
   input  logic signed [qrm_pkg::IN_WIDTH-1:0] in_z,
   input  logic signed [qrm_pkg::IN_WIDTH-1:0] in_w,
   output qrm_pkg::div_word_type               out_word
);

   typedef struct packed {
      logic                                      vld;
      logic                                      zero;
      logic signed [qrm_pkg::PROD_WIDTH-1:0]     xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
   } prod_type;

   typedef struct packed {
      logic                                                         vld;
      logic                                                         zero;
      logic [qrm_pkg::DEN_WIDTH-1:0]                                den;
      logic [qrm_pkg::NUM_ENTRIES-1:0][qrm_pkg::SUM_WIDTH-1:0]      num;
   } sum_type;

   prod_type               prod_ff, prod_in;
   sum_type                sum_ff, sum_in;
   qrm_pkg::div_word_type  word_ff, word_in;

   logic                                 all_even;
   logic signed [qrm_pkg::IN_WIDTH-1:0]  hx, hy, hz, hw;

   // stage 1: drop a common factor of two, form the ten products
   always_comb begin
      all_even = !(in_x[0] | in_y[0] | in_z[0] | in_w[0]);
      hx = all_even ? (in_x >>> 1) : in_x;
      hy = all_even ? (in_y >>> 1) : in_y;
      hz = all_even ? (in_z >>> 1) : in_z;
      hw = all_even ? (in_w >>> 1) : in_w;
      prod_in.vld  = in_vld;
      prod_in.zero = (in_x == '0) && (in_y == '0) && (in_z == '0) && (in_w == '0);
      prod_in.xx = hx * hx;
      prod_in.yy = hy * hy;
      prod_in.zz = hz * hz;
      prod_in.ww = hw * hw;
      prod_in.xy = hx * hy;
      prod_in.xz = hx * hz;
      prod_in.yz = hy * hz;
      prod_in.wx = hw * hx;
      prod_in.wy = hw * hy;
      prod_in.wz = hw * hz;
   end

   // stage 2: numerators and norm
   always_comb begin
      logic signed [qrm_pkg::SUM_WIDTH-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
      exx = qrm_pkg::SUM_WIDTH'(prod_ff.xx);
      eyy = qrm_pkg::SUM_WIDTH'(prod_ff.yy);
      ezz = qrm_pkg::SUM_WIDTH'(prod_ff.zz);
      eww = qrm_pkg::SUM_WIDTH'(prod_ff.ww);
      exy = qrm_pkg::SUM_WIDTH'(prod_ff.xy);
      exz = qrm_pkg::SUM_WIDTH'(prod_ff.xz);
      eyz = qrm_pkg::SUM_WIDTH'(prod_ff.yz);
      ewx = qrm_pkg::SUM_WIDTH'(prod_ff.wx);
      ewy = qrm_pkg::SUM_WIDTH'(prod_ff.wy);
      ewz = qrm_pkg::SUM_WIDTH'(prod_ff.wz);
      sum_in.vld  = prod_ff.vld;
      sum_in.zero = prod_ff.zero;
      sum_in.den  = qrm_pkg::DEN_WIDTH'(exx + eyy + ezz + eww);
      // off-diagonal numerators are doubled so every entry divides the same way
      sum_in.num[qrm_pkg::E_R0C0] = exx + eww - eyy - ezz;
      sum_in.num[qrm_pkg::E_R0C1] = (exy + ewz) <<< 1;
      sum_in.num[qrm_pkg::E_R0C2] = (exz - ewy) <<< 1;
      sum_in.num[qrm_pkg::E_R1C0] = (exy - ewz) <<< 1;
      sum_in.num[qrm_pkg::E_R1C1] = eyy + eww - exx - ezz;
      sum_in.num[qrm_pkg::E_R1C2] = (eyz + ewx) <<< 1;
      sum_in.num[qrm_pkg::E_R2C0] = (exz + ewy) <<< 1;
      sum_in.num[qrm_pkg::E_R2C1] = (eyz - ewx) <<< 1;
      sum_in.num[qrm_pkg::E_R2C2] = ezz + eww - exx - eyy;
   end

   // stage 3: sign and magnitude, integer quotient bit
   always_comb begin
      logic [qrm_pkg::SUM_WIDTH-1:0] mag;
      logic [qrm_pkg::DEN_WIDTH-1:0] mag_n;
      mag   = '0;
      mag_n = '0;
      word_in.vld  = sum_ff.vld;
      word_in.zero = sum_ff.zero;
      word_in.den  = sum_ff.den;
      for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
         word_in.neg[i] = sum_ff.num[i][qrm_pkg::SUM_WIDTH-1];
         mag = word_in.neg[i] ? (~sum_ff.num[i] + 1'b1) : sum_ff.num[i];
         mag_n = mag[qrm_pkg::DEN_WIDTH-1:0];
         if (mag_n == sum_ff.den) begin
            word_in.rem[i] = '0;
            word_in.quo[i] = qrm_pkg::QUO_WIDTH'(1);
         end else begin
            word_in.rem[i] = mag_n;
            word_in.quo[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.vld <= 1'b0;
         sum_ff.vld  <= 1'b0;
         word_ff.vld <= 1'b0;
      end else if (enable) begin
         prod_ff.vld <= prod_in.vld;
         sum_ff.vld  <= sum_in.vld;
         word_ff.vld <= word_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff.zero <= prod_in.zero;
         prod_ff.xx <= prod_in.xx;
         prod_ff.yy <= prod_in.yy;
         prod_ff.zz <= prod_in.zz;
         prod_ff.ww <= prod_in.ww;
         prod_ff.xy <= prod_in.xy;
         prod_ff.xz <= prod_in.xz;
         prod_ff.yz <= prod_in.yz;
         prod_ff.wx <= prod_in.wx;
         prod_ff.wy <= prod_in.wy;
         prod_ff.wz <= prod_in.wz;
         sum_ff.zero <= sum_in.zero;
         sum_ff.den  <= sum_in.den;
         sum_ff.num  <= sum_in.num;
         word_ff.zero <= word_in.zero;
         word_ff.den  <= word_in.den;
         word_ff.neg  <= word_in.neg;
         word_ff.rem  <= word_in.rem;
         word_ff.quo  <= word_in.quo;
      end
   end

   assign out_word = word_ff;

endmodule

// File: rtl/qrm_div_stage.sv
`timescale 1ns / 1ps

module qrm_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  qrm_pkg::div_word_type in_word,
   output qrm_pkg::div_word_type out_word
);

   qrm_pkg::div_word_type word_ff, word_in;

   // one restoring step, one fraction bit per entry
   always_comb begin
      logic [qrm_pkg::DEN_WIDTH:0] two_r;
      logic [qrm_pkg::DEN_WIDTH:0] diff;
      two_r = '0;
      diff  = '0;
      word_in = in_word;
      for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
         two_r = {in_word.rem[i], 1'b0};
         diff  = two_r - {1'b0, in_word.den};
         if (two_r >= {1'b0, in_word.den}) begin
            word_in.rem[i] = diff[qrm_pkg::DEN_WIDTH-1:0];
            word_in.quo[i] = {in_word.quo[i][qrm_pkg::QUO_WIDTH-2:0], 1'b1};
         end else begin
            word_in.rem[i] = two_r[qrm_pkg::DEN_WIDTH-1:0];
            word_in.quo[i] = {in_word.quo[i][qrm_pkg::QUO_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else if (enable) begin
         word_ff.vld <= word_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff.zero <= word_in.zero;
         word_ff.den  <= word_in.den;
         word_ff.neg  <= word_in.neg;
         word_ff.rem  <= word_in.rem;
         word_ff.quo  <= word_in.quo;
      end
   end

   assign out_word = word_ff;

endmodule

// File: rtl/qrm_round.sv
`timescale 1ns / 1ps

module qrm_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  qrm_pkg::div_word_type in_word,
   output qrm_pkg::result_type   out_res
);

   qrm_pkg::result_type res_ff, res_in;

   // round half away from zero on the magnitude, clamp, apply sign; an all-zero input gives the identity
   always_comb begin
      logic [qrm_pkg::DEN_WIDTH:0]   two_r;
      logic [qrm_pkg::OUT_WIDTH-1:0] qsum;
      logic [qrm_pkg::OUT_WIDTH-1:0] sat;
      two_r = '0;
      qsum  = '0;
      sat   = '0;
      res_in.vld  = in_word.vld;
      res_in.zero = in_word.zero;
      for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
         two_r = {in_word.rem[i], 1'b0};
         qsum  = qrm_pkg::OUT_WIDTH'(in_word.quo[i])
               + qrm_pkg::OUT_WIDTH'(two_r >= {1'b0, in_word.den});
         sat   = (qsum > qrm_pkg::FIX_ONE) ? qrm_pkg::FIX_ONE : qsum;
         res_in.ent[i] = in_word.neg[i] ? (~sat + 1'b1) : sat;
      end
      if (in_word.zero) begin
         res_in.ent = '0;
         res_in.ent[qrm_pkg::E_R0C0] = qrm_pkg::FIX_ONE;
         res_in.ent[qrm_pkg::E_R1C1] = qrm_pkg::FIX_ONE;
         res_in.ent[qrm_pkg::E_R2C2] = qrm_pkg::FIX_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.vld <= 1'b0;
      end else if (enable) begin
         res_ff.vld <= res_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff.zero <= res_in.zero;
         res_ff.ent  <= res_in.ent;
      end
   end

   assign out_res = res_ff;

endmodule

// File: rtl/quaternion_to_rotation_matrix_top.sv
// throughput: one transaction per cycle; the whole pipeline holds while a response waits
// stages: 1 multiply, 1 sum, 1 sign/integer bit, 14 divide steps, 1 round and clamp
// reset: synchronous, active high; clears all stage valid bits, no data is reset
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_top (
   input  logic          clock,
   input  logic          reset,
   qrm_req_if.sink       req,
   qrm_rsp_if.source     rsp
);

   logic                  enable;
   qrm_pkg::div_word_type stage_word [qrm_pkg::DIV_STAGES+1];
   qrm_pkg::result_type   res;

   assign enable    = !rsp.valid || rsp.ready;
   assign req.ready = enable;

   qrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_vld   (req.valid),
      .in_x     (req.quat_x),
      .in_y     (req.quat_y),
      .in_z     (req.quat_z),
      .in_w     (req.quat_w),
      .out_word (stage_word[0])
   );

   for (genvar g = 0; g < qrm_pkg::DIV_STAGES; g++) begin : g_div
      qrm_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_word  (stage_word[g]),
         .out_word (stage_word[g+1])
      );
   end

   qrm_round u_round (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .in_word (stage_word[qrm_pkg::DIV_STAGES]),
      .out_res (res)
   );

   assign rsp.valid       = res.vld;
   assign rsp.zero_length = res.zero;
   assign rsp.r0c0 = res.ent[qrm_pkg::E_R0C0];
   assign rsp.r0c1 = res.ent[qrm_pkg::E_R0C1];
   assign rsp.r0c2 = res.ent[qrm_pkg::E_R0C2];
   assign rsp.r1c0 = res.ent[qrm_pkg::E_R1C0];
   assign rsp.r1c1 = res.ent[qrm_pkg::E_R1C1];
   assign rsp.r1c2 = res.ent[qrm_pkg::E_R1C2];
   assign rsp.r2c0 = res.ent[qrm_pkg::E_R2C0];
   assign rsp.r2c1 = res.ent[qrm_pkg::E_R2C1];
   assign rsp.r2c2 = res.ent[qrm_pkg::E_R2C2];

endmodule

// File: sim/tb_quaternion_to_rotation_matrix_top.sv
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix_top;

   typedef logic signed [qrm_pkg::IN_WIDTH-1:0]  quat_comp_type;
   typedef logic signed [qrm_pkg::OUT_WIDTH-1:0] fix_type;

   typedef struct {
      quat_comp_type x, y, z, w;
   } quat_type;

   typedef struct {
      fix_type ent [qrm_pkg::NUM_ENTRIES];
      logic    zero;
   } matrix_type;

   typedef struct {
      quat_type   q;
      logic       known;
      matrix_type m;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qrm_req_if req ();
   qrm_rsp_if rsp ();

   quaternion_to_rotation_matrix_top u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   matrix_type  pending_matrices [$];
   vector_type  directed [$];
   int          error_count = 0;
   int          matrices_checked = 0;
   int          zero_count = 0;
   int          quats_sent = 0;
   bit          stall_long = 1'b0;
   bit          stim_done = 1'b0;

   // signed magnitude arithmetic, wide enough for any sum of products
   function automatic logic [79:0] div_round(input logic [79:0] num_mag, input logic [79:0] den,
                                             input int bits);
      logic [79:0] quo;
      logic [79:0] rem;
      quo = '0;
      rem = num_mag;
      if (rem >= den) begin
         quo = 80'd1;
         rem = rem - den;
      end
      for (int i = 0; i < bits; i++) begin
         quo = quo << 1;
         if (rem >= den - rem) begin
            rem = rem - (den - rem);
            quo[0] = 1'b1;
         end else begin
            rem = rem + rem;
         end
      end
      if (rem >= den - rem) quo = quo + 80'd1;
      if (quo > (80'd1 << qrm_pkg::OUT_FRAC_BITS)) quo = 80'd1 << qrm_pkg::OUT_FRAC_BITS;
      return quo;
   endfunction

   function automatic fix_type entry_of(input longint signed num, input longint unsigned den,
                                        input int bits);
      logic [79:0] mag;
      logic [79:0] q;
      mag = (num < 0) ? 80'(-num) : 80'(num);
      q = div_round(mag, 80'(den), bits);
      if (num < 0) q = -q;
      return fix_type'(q[qrm_pkg::OUT_WIDTH-1:0]);
   endfunction

   function automatic matrix_type rotation_of(input quat_type q);
      matrix_type m;
      longint signed x, y, z, w;
      longint signed xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
      longint unsigned n;
      x = longint'(q.x); y = longint'(q.y); z = longint'(q.z); w = longint'(q.w);
      m.zero = 1'b0;
      if (x == 0 && y == 0 && z == 0 && w == 0) begin
         foreach (m.ent[k]) m.ent[k] = '0;
         m.ent[qrm_pkg::E_R0C0] = qrm_pkg::FIX_ONE;
         m.ent[qrm_pkg::E_R1C1] = qrm_pkg::FIX_ONE;
         m.ent[qrm_pkg::E_R2C2] = qrm_pkg::FIX_ONE;
         m.zero = 1'b1;
         return m;
      end
      if (((x | y | z | w) & 1) == 0) begin
         x = x / 2; y = y / 2; z = z / 2; w = w / 2;
      end
      xx = x * x; yy = y * y; zz = z * z; ww = w * w;
      xy = x * y; xz = x * z; yz = y * z;
      wx = w * x; wy = w * y; wz = w * z;
      n = xx + yy + zz + ww;
      m.ent[qrm_pkg::E_R0C0] = entry_of(xx + ww - yy - zz, n, qrm_pkg::OUT_FRAC_BITS);
      m.ent[qrm_pkg::E_R0C1] = entry_of(xy + wz, n, qrm_pkg::OUT_FRAC_BITS + 1);
      m.ent[qrm_pkg::E_R0C2] = entry_of(xz - wy, n, qrm_pkg::OUT_FRAC_BITS + 1);
      m.ent[qrm_pkg::E_R1C0] = entry_of(xy - wz, n, qrm_pkg::OUT_FRAC_BITS + 1);
      m.ent[qrm_pkg::E_R1C1] = entry_of(yy + ww - xx - zz, n, qrm_pkg::OUT_FRAC_BITS);
      m.ent[qrm_pkg::E_R1C2] = entry_of(yz + wx, n, qrm_pkg::OUT_FRAC_BITS + 1);
      m.ent[qrm_pkg::E_R2C0] = entry_of(xz + wy, n, qrm_pkg::OUT_FRAC_BITS + 1);
      m.ent[qrm_pkg::E_R2C1] = entry_of(yz - wx, n, qrm_pkg::OUT_FRAC_BITS + 1);
      m.ent[qrm_pkg::E_R2C2] = entry_of(zz + ww - xx - yy, n, qrm_pkg::OUT_FRAC_BITS);
      return m;
   endfunction

   function automatic quat_comp_type rand_comp();
      case ($urandom_range(0, 7))
         0: return quat_comp_type'(16'h8000);
         1: return quat_comp_type'(16'h7fff);
         2: return quat_comp_type'($urandom_range(0, 6) - 3);
         3: return quat_comp_type'($urandom_range(0, 511) - 256);
         default: return quat_comp_type'($urandom);
      endcase
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   task automatic add_row(input int x, input int y, input int z, input int w, input logic known,
                          input fix_type d0, input fix_type d1, input fix_type d2);
      vector_type v;
      v.q = '{quat_comp_type'(x), quat_comp_type'(y), quat_comp_type'(z), quat_comp_type'(w)};
      v.known = known;
      foreach (v.m.ent[k]) v.m.ent[k] = '0;
      v.m.ent[qrm_pkg::E_R0C0] = d0;
      v.m.ent[qrm_pkg::E_R1C1] = d1;
      v.m.ent[qrm_pkg::E_R2C2] = d2;
      v.m.zero = (x == 0 && y == 0 && z == 0 && w == 0);
      directed.push_back(v);
   endtask

   task automatic send_quat(input quat_type q);
      req.valid  <= 1'b1;
      req.quat_x <= q.x;
      req.quat_y <= q.y;
      req.quat_z <= q.z;
      req.quat_w <= q.w;
      do @(posedge clock); while (!req.ready);
      pending_matrices.push_back(rotation_of(q));
      quats_sent++;
   endtask

   task automatic idle_for(input int n);
      if (n == 0) return;
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // response side
   always @(posedge clock) begin
      matrix_type e;
      fix_type got [qrm_pkg::NUM_ENTRIES];
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.r0c0, rsp.r0c1, rsp.r0c2, rsp.r1c0, rsp.r1c1, rsp.r1c2,
                 rsp.r2c0, rsp.r2c1, rsp.r2c2};
         if (pending_matrices.size() == 0) begin
            $display("%0t: unexpected transaction on rsp", $time);
            error_count++;
         end else begin
            e = pending_matrices.pop_front();
            foreach (got[k])
               if (got[k] !== e.ent[k]) begin
                  $display("%0t: entry %0d expected %0d actual %0d", $time, k, e.ent[k], got[k]);
                  error_count++;
               end
            if (rsp.zero_length !== e.zero) begin
               $display("%0t: zero_length expected %0b actual %0b", $time, e.zero,
                        rsp.zero_length);
               error_count++;
            end
            matrices_checked++;
            if (e.zero) zero_count++;
         end
      end
   end

   initial begin
      int gap;
      rsp.ready <= 1'b0;
      while (!stim_done || pending_matrices.size() != 0) begin
         @(posedge clock);
         if (stall_long) begin
            rsp.ready <= 1'b0;
            repeat (60) @(posedge clock);
            stall_long = 1'b0;
         end
         gap = $urandom_range(0, 30) < 20 ? 0 : rand_gap();
         if (gap == 0 || quats_sent > 1200) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
      end
   end

   initial begin
      #20ms;
      $display("tb_quaternion_to_rotation_matrix_top failed");
      $finish;
   end

   initial begin
      quat_type q;
      vector_type v;
      req.valid  <= 1'b0;
      req.quat_x <= '0;
      req.quat_y <= '0;
      req.quat_z <= '0;
      req.quat_w <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity cases and single axis extremes with typed diagonals, then mixed cases left to the predictor
      add_row(0, 0, 0, 0, 1'b1, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE);
      add_row(0, 0, 0, 1, 1'b1, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE);
      add_row(0, 0, 0, 32767, 1'b1, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE);
      add_row(0, 0, 0, -32768, 1'b1, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE);
      add_row(32767, 0, 0, 0, 1'b1, qrm_pkg::FIX_ONE, -qrm_pkg::FIX_ONE, -qrm_pkg::FIX_ONE);
      add_row(0, -32768, 0, 0, 1'b1, -qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE, -qrm_pkg::FIX_ONE);
      add_row(0, 0, 1, 0, 1'b1, -qrm_pkg::FIX_ONE, -qrm_pkg::FIX_ONE, qrm_pkg::FIX_ONE);
      add_row(-32768, -32768, -32768, -32768, 1'b0, 0, 0, 0);
      add_row(32767, 32767, 32767, 32767, 1'b0, 0, 0, 0);
      add_row(32767, -32768, 32767, -32768, 1'b0, 0, 0, 0);
      add_row(1, 1, 1, 1, 1'b0, 0, 0, 0);
      add_row(1, 0, 0, 1, 1'b0, 0, 0, 0);
      add_row(0, 1, 0, -1, 1'b0, 0, 0, 0);
      add_row(0, 0, -1, 1, 1'b0, 0, 0, 0);
      add_row(1, 2, 3, 4, 1'b0, 0, 0, 0);
      add_row(-1, -2, 2, -3, 1'b0, 0, 0, 0);
      add_row(2, 4, 6, 8, 1'b0, 0, 0, 0);
      add_row(1, 1, 0, 0, 1'b0, 0, 0, 0);
      add_row(3, 0, 0, 1, 1'b0, 0, 0, 0);
      add_row(-21846, 21845, 1, -7, 1'b0, 0, 0, 0);

      foreach (directed[i]) begin
         v = directed[i];
         send_quat(v.q);
         if (v.known) begin
            // typed rows replace the predictor entry made by send_quat
            pending_matrices[pending_matrices.size() - 1] = v.m;
         end
         idle_for(rand_gap());
      end

      idle_for(1);
      stall_long = 1'b1;
      for (int i = 0; i < 1700; i++) begin
         q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
         if ($urandom_range(0, 40) == 0) q = '{'0, '0, '0, '0};
         send_quat(q);
         if (i == 100) stall_long = 1'b1;
         if (i == 800) begin
            req.valid <= 1'b0;
            wait (pending_matrices.size() == 0);
            @(posedge clock);
         end else if (i > 300 && i < 600 || i > 1200) begin
            idle_for(0);
         end else begin
            idle_for(rand_gap());
         end
      end
      req.valid <= 1'b0;
      stim_done = 1'b1;
      wait (pending_matrices.size() == 0);
      repeat (30) @(posedge clock);

      $display("covered %0d quaternions, %0d matrices checked, %0d all-zero inputs",
               quats_sent, matrices_checked, zero_count);
      $display("stimulus held the input through long output stalls and one full drain");
      if (error_count == 0 && pending_matrices.size() == 0) begin
         $display("tb_quaternion_to_rotation_matrix_top passed");
      end else begin
         $display("tb_quaternion_to_rotation_matrix_top failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/qrm_pkg.sv
rtl/qrm_if.sv
rtl/qrm_front.sv
rtl/qrm_div_stage.sv
rtl/qrm_round.sv
rtl/quaternion_to_rotation_matrix_top.sv
sim/tb_quaternion_to_rotation_matrix_top.sv
